FILE: rtl/rbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types, widths and codes of the rANS block encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

    // alphabet and count sizing
    localparam int ALPHABET_SIZE = 1024;
    localparam int COUNT_BITS    = 20;
    localparam int TABLE_DEPTH   = ALPHABET_SIZE + 1;
    localparam int TBL_AW        = $clog2(TABLE_DEPTH);
    localparam int SYM_W         = $clog2(ALPHABET_SIZE);
    localparam int VAL_W         = COUNT_BITS + 1;

    // coder state and result sizing
    localparam int STATE_W   = 53;
    localparam int OUT_W     = 52;
    localparam int MAX_WORDS = 23;
    localparam int NCNT_W    = $clog2(MAX_WORDS + 1);
    localparam int DCNT_W    = $clog2(STATE_W);
    localparam int WORD_W    = 32;
    localparam int WBITS_W   = 6;

    // item field widths
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int APB_DW  = 32;

    // operations
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

    // register indexes
    localparam logic REG_TOTAL_COUNT = 1'b0;
    localparam logic REG_WORD_BITS   = 1'b1;

    // reset values
    localparam logic [VAL_W-1:0]   M_RESET     = 21'd1048576;
    localparam logic [WBITS_W-1:0] WBITS_RESET = 6'd16;

    // table write port
    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_tbl_wr;

endpackage

FILE: rtl/rbe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbe_in_if / rbe_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface rbe_in_if;
    import rbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TBL_AW-1:0] table_index;
    logic [VAL_W-1:0]  table_value;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output operation, output table_index,
                    output table_value, output symbol, input ready);
    modport sink   (input valid, input operation, input table_index,
                    input table_value, input symbol, output ready);
endinterface

interface rbe_out_if;
    import rbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  out_value;
    logic [KIND_W-1:0] kind;
    logic              last;

    modport source (output valid, output out_value, output kind, output last,
                    input ready);
    modport sink   (input valid, input out_value, input kind, input last,
                    output ready);
endinterface

FILE: rtl/rbe_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbe_table
// Cumulative frequency table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbe_table (
    input  logic                          i_clk,
    input  rbe_pkg::t_tbl_wr              i_wr,
    input  logic [rbe_pkg::TBL_AW-1:0]    i_rd_addr,
    output logic [rbe_pkg::VAL_W-1:0]     o_rd_data
);
    import rbe_pkg::*;

    logic [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rans_block_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rans_block_encoder_top
// rANS encoder with a loadable cumulative frequency table.
// ----------------------------------------------------------------------------
// usage:
//   i_item carries load, encode and flush items; o_result carries emitted
//   words, the flushed final state and zero-width error markers, with last
//   set on the final result of each item. the user must write total_count
//   and word_bits over APB while the block is idle; the block does not check.
// timing:
//   a load writes its table entry and gives no result. a flush emits the
//   final state. an encode reads the table in ST_RD0 and ST_RD1, checks the
//   width in ST_CHK, emits one word per cycle in ST_RENORM while the output
//   register is free, then runs the combined divide/multiply step in ST_DIV
//   and 2 finishing adds in ST_FIN1 and ST_FIN2.
//   i_item.ready is high only while the sequencer is idle.
// reset:
//   coder state clears to zero, registers return to their defaults; the
//   table holds no defined contents until loaded.
// stalls:
//   results sit in one output register; while the receiver stalls the
//   sequencer holds before the next emit.
// ----------------------------------------------------------------------------
module rans_block_encoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rbe_in_if.sink                         i_item,
    rbe_out_if.source                      o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rbe_pkg::PADDR_W-1:0]    paddr,
    input  logic [rbe_pkg::APB_DW-1:0]     pwdata,
    output logic [rbe_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import rbe_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD0    = 4'd1;
    localparam logic [3:0] ST_RD1    = 4'd2;
    localparam logic [3:0] ST_CHK    = 4'd3;
    localparam logic [3:0] ST_RENORM = 4'd4;
    localparam logic [3:0] ST_DIV    = 4'd5;
    localparam logic [3:0] ST_FIN1   = 4'd6;
    localparam logic [3:0] ST_FIN2   = 4'd7;
    localparam logic [3:0] ST_FLUSH  = 4'd8;
    localparam logic [3:0] ST_ERR    = 4'd9;

    logic [3:0]         r_fsm;
    logic [VAL_W-1:0]   r_m;
    logic [WBITS_W-1:0] r_wbits;
    logic [STATE_W-1:0] r_state;
    logic [SYM_W-1:0]   r_sym;
    logic [VAL_W-1:0]   r_base;
    logic [VAL_W-1:0]   r_width;
    logic [STATE_W-1:0] r_s;
    logic [STATE_W-1:0] r_hi;
    logic [STATE_W-1:0] r_acc;
    logic [VAL_W-1:0]   r_rem;
    logic [NCNT_W-1:0]  r_n;
    logic [DCNT_W-1:0]  r_cnt;
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_oval;
    logic [KIND_W-1:0]  r_okind;
    logic               r_olast;

    logic               in_acc;
    logic               slot_free;
    logic               emit;
    logic               cfg_wr;
    logic [WBITS_W-1:0] bits_eff;
    logic [WORD_W-1:0]  word_mask;
    logic [STATE_W-1:0] sh_in;
    logic [STATE_W-1:0] sh_out;
    logic [STATE_W-1:0] width_ext;
    logic               more;
    logic               next_more;
    logic [VAL_W:0]     div_t;
    logic               div_ge;
    logic [VAL_W-1:0]   div_rem;
    logic [STATE_W-1:0] acc_next;
    t_tbl_wr            tbl_wr;
    logic [TBL_AW-1:0]  tbl_rd_addr;
    logic [VAL_W-1:0]   tbl_rd_data;

    // handshakes
    assign i_item.ready = (r_fsm == ST_IDLE);
    assign in_acc       = i_item.valid && i_item.ready;
    assign slot_free    = !r_ovalid || o_result.ready;

    assign o_result.valid     = r_ovalid;
    assign o_result.out_value = r_oval;
    assign o_result.kind      = r_okind;
    assign o_result.last      = r_olast;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_TOTAL_COUNT) ? APB_DW'(r_m)
                                                          : APB_DW'(r_wbits);

    // word size clamped to 1..32
    always_comb begin
        if (r_wbits == '0) begin
            bits_eff = WBITS_W'(1);
        end else if (r_wbits > WBITS_W'(WORD_W)) begin
            bits_eff = WBITS_W'(WORD_W);
        end else begin
            bits_eff = r_wbits;
        end
    end

    assign word_mask = {WORD_W{1'b1}} >> (WBITS_W'(WORD_W) - bits_eff);

    // shared barrel shifter for renormalisation
    assign sh_in     = (r_fsm == ST_CHK) ? r_state : r_hi;
    assign sh_out    = sh_in >> bits_eff;
    assign width_ext = {{(STATE_W-VAL_W){1'b0}}, r_width};
    assign more      = (r_hi >= width_ext);
    assign next_more = (sh_out >= width_ext);

    // output register loads a new item this cycle
    assign emit = slot_free
               && (((r_fsm == ST_RENORM) && more && (r_n < NCNT_W'(MAX_WORDS)))
                   || (r_fsm == ST_FLUSH) || (r_fsm == ST_ERR));

    // bit-serial divide with the multiply by m folded in (horner form)
    assign div_t    = {r_rem, r_s[STATE_W-1]};
    assign div_ge   = (div_t >= {1'b0, r_width});
    assign div_rem  = div_ge ? VAL_W'(div_t - {1'b0, r_width}) : VAL_W'(div_t);
    assign acc_next = {r_acc[STATE_W-2:0], 1'b0}
                    + (div_ge ? {{(STATE_W-VAL_W){1'b0}}, r_m} : '0);

    // table access
    assign tbl_wr.en   = in_acc && (i_item.operation == OP_LOAD)
                      && (i_item.table_index < TBL_AW'(TABLE_DEPTH));
    assign tbl_wr.addr = i_item.table_index;
    assign tbl_wr.data = i_item.table_value;
    assign tbl_rd_addr = (r_fsm == ST_RD1) ? TBL_AW'({1'b0, r_sym}) + TBL_AW'(1)
                                           : TBL_AW'({1'b0, r_sym});

    rbe_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd_data)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_IDLE;
            r_m      <= M_RESET;
            r_wbits  <= WBITS_RESET;
            r_state  <= '0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_cnt    <= '0;
        end else begin
            // register writes
            if (cfg_wr) begin
                if (paddr[PADDR_W-1] == REG_TOTAL_COUNT) begin
                    r_m <= pwdata[VAL_W-1:0];
                end else begin
                    r_wbits <= pwdata[WBITS_W-1:0];
                end
            end

            if (slot_free && !emit) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_fsm)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (i_item.operation)
                            OP_LOAD: begin
                                r_state <= {{(STATE_W-VAL_W){1'b0}}, r_m};
                            end
                            OP_ENCODE: begin
                                r_sym <= i_item.symbol;
                                r_fsm <= ST_RD0;
                            end
                            OP_FLUSH: begin
                                r_fsm <= ST_FLUSH;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RD0: begin
                    r_fsm <= ST_RD1;
                end
                ST_RD1: begin
                    r_base <= tbl_rd_data;
                    r_fsm  <= ST_CHK;
                end
                // width check and renormalisation setup
                ST_CHK: begin
                    if (tbl_rd_data <= r_base) begin
                        r_fsm <= ST_ERR;
                    end else begin
                        r_width <= tbl_rd_data - r_base;
                        r_s     <= r_state;
                        r_hi    <= sh_out;
                        r_n     <= '0;
                        r_fsm   <= ST_RENORM;
                    end
                end
                // one word per cycle while the state is too large and the output slot is free
                ST_RENORM: begin
                    if (more && (r_n < NCNT_W'(MAX_WORDS))) begin
                        if (slot_free) begin
                            r_ovalid <= 1'b1;
                            r_oval   <= OUT_W'(r_s[WORD_W-1:0] & word_mask);
                            r_okind  <= KIND_WORD;
                            r_olast  <= !next_more || (r_n == NCNT_W'(MAX_WORDS - 1));
                            r_s      <= r_hi;
                            r_hi     <= sh_out;
                            r_n      <= r_n + NCNT_W'(1);
                        end
                    end else begin
                        r_rem <= '0;
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_fsm <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= div_rem;
                    r_acc <= acc_next;
                    r_s   <= {r_s[STATE_W-2:0], 1'b0};
                    r_cnt <= r_cnt + DCNT_W'(1);
                    if (r_cnt == DCNT_W'(STATE_W - 1)) begin
                        r_fsm <= ST_FIN1;
                    end
                end
                ST_FIN1: begin
                    r_acc <= r_acc + {{(STATE_W-VAL_W){1'b0}}, r_rem};
                    r_fsm <= ST_FIN2;
                end
                ST_FIN2: begin
                    r_state <= r_acc + {{(STATE_W-VAL_W){1'b0}}, r_base};
                    r_fsm   <= ST_IDLE;
                end
                ST_FLUSH: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_state[OUT_W-1:0];
                        r_okind  <= KIND_FINAL;
                        r_olast  <= 1'b1;
                        r_state  <= {{(STATE_W-VAL_W){1'b0}}, r_m};
                        r_fsm    <= ST_IDLE;
                    end
                end
                ST_ERR: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= '0;
                        r_okind  <= KIND_ERR;
                        r_olast  <= 1'b1;
                        r_fsm    <= ST_IDLE;
                    end
                end
                default: begin
                    r_fsm <= ST_IDLE;
                end
            endcase
        end
    end

    // word count never passes the cap
    a_word_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NCNT_W'(MAX_WORDS))
        else $error("renormalisation word count above cap");

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_DIV) |-> (r_rem < r_width))
        else $error("divider remainder out of range");

    // final state and error results always close their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind != KIND_WORD)) |-> r_olast)
        else $error("single result without last");

endmodule

FILE: tb/rans_block_encoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rans_block_encoder_top_test
// Self-checking bench for the rANS block encoder. Directed rows first, then
// random phases. Each phase sets the modulus and word size, loads a short
// segment of the cumulative table and encodes symbols of that segment.
// The bench keeps its own copy of the table and the coder state. It works
// out the expected words, final states and error markers for each item,
// then compares them in order with what the block emits, while both sides
// of the block are stalled at random.
// ----------------------------------------------------------------------------
module rans_block_encoder_top_test;
    import rbe_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int ITEM_TARGET   = 210;
    localparam int CALM_AFTER    = 185;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_PHASE    = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int VALUE_MAX     = (1 << VAL_W) - 1;
    localparam int INDEX_MAX     = (1 << TBL_AW) - 1;

    // operation code that the block ignores
    localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0]  value;
        logic [KIND_W-1:0] kind;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TBL_AW-1:0] index;
        logic [VAL_W-1:0]  value;
        logic [SYM_W-1:0]  symbol;
        logic              typed;
        logic              typed_any;
        result_t           typed_res;
    } stim_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    rbe_in_if  item_if ();
    rbe_out_if res_if ();

    rans_block_encoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the coder
    logic [VAL_W-1:0]   cum_freq [0:TABLE_DEPTH-1];
    logic [STATE_W-1:0] coder_state = '0;
    logic [VAL_W-1:0]   modulus     = M_RESET;
    logic [WBITS_W-1:0] word_size   = WBITS_RESET;

    result_t coder_outputs_due [$];

    int  fail_count     = 0;
    int  items_sent     = 0;
    int  words_seen     = 0;
    int  finals_seen    = 0;
    int  errors_seen    = 0;
    int  phases_run     = 0;
    bit  calm           = 1'b0;
    bit  hold_long      = 1'b0;

    // step the shadow coder by one item, queueing its results when asked
    function automatic void advance_coder(input stim_t s, input bit record);
        logic [63:0] base;
        logic [63:0] top;
        logic [63:0] span;
        logic [63:0] limit;
        logic [63:0] acc;
        int unsigned shift;
        int          n;
        result_t     r;
        shift = word_size;
        if (shift < 1) shift = 1;
        if (shift > 32) shift = 32;
        case (s.op)
            OP_LOAD: begin
                if (s.index < TABLE_DEPTH) cum_freq[s.index] = s.value;
                coder_state = STATE_W'(modulus);
            end
            OP_FLUSH: begin
                r.value = coder_state[OUT_W-1:0];
                r.kind  = KIND_FINAL;
                r.last  = 1'b1;
                if (record) coder_outputs_due.push_back(r);
                coder_state = STATE_W'(modulus);
            end
            OP_ENCODE: begin
                base = cum_freq[s.symbol];
                top  = cum_freq[int'(s.symbol) + 1];
                if (top <= base) begin
                    r.value = '0;
                    r.kind  = KIND_ERR;
                    r.last  = 1'b1;
                    if (record) coder_outputs_due.push_back(r);
                end else begin
                    span  = top - base;
                    limit = (span << shift) - 1;
                    acc   = coder_state;
                    n     = 0;
                    // renormalize: shift out low words until the state fits
                    while (acc > limit && n < MAX_WORDS) begin
                        r.value = OUT_W'(acc & ((64'd1 << shift) - 1));
                        r.kind  = KIND_WORD;
                        acc     = acc >> shift;
                        n++;
                        r.last  = !(acc > limit && n < MAX_WORDS);
                        if (record) coder_outputs_due.push_back(r);
                    end
                    coder_state = STATE_W'(64'(modulus) * (acc / span) + base + acc % span);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic stim_t row(input logic [OP_W-1:0] op, input int idx,
                                  input int val, input int sym);
        stim_t s;
        s        = '0;
        s.op     = op;
        s.index  = TBL_AW'(idx);
        s.value  = VAL_W'(val);
        s.symbol = SYM_W'(sym);
        return s;
    endfunction

    function automatic stim_t row_typed(input logic [OP_W-1:0] op, input int idx,
                                        input int val, input int sym, input bit any,
                                        input logic [OUT_W-1:0] v,
                                        input logic [KIND_W-1:0] k);
        stim_t s;
        s                 = row(op, idx, val, sym);
        s.typed           = 1'b1;
        s.typed_any       = any;
        s.typed_res.value = v;
        s.typed_res.kind  = k;
        s.typed_res.last  = 1'b1;
        return s;
    endfunction

    // offer one item and wait for the block to take it
    task automatic send_item(input stim_t s);
        item_if.valid       <= 1'b1;
        item_if.operation   <= s.op;
        item_if.table_index <= s.index;
        item_if.table_value <= s.value;
        item_if.symbol      <= s.symbol;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        if (s.op != OP_RSVD) items_sent++;
        calm = (items_sent >= CALM_AFTER);
        advance_coder(s, !s.typed);
        if (s.typed && s.typed_any) coder_outputs_due.push_back(s.typed_res);
    endtask

    // random sender gap ahead of the item
    task automatic offer(input stim_t s);
        if (!calm && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        send_item(s);
    endtask

    // wait until the block has nothing left to say and has gone quiet
    task automatic settle();
        item_if.valid <= 1'b0;
        while (coder_outputs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup then access, then one idle bus cycle
    task automatic reg_write(input logic reg_idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_TOTAL_COUNT) modulus = data[VAL_W-1:0];
        else word_size = data[WBITS_W-1:0];
        @(posedge i_clk);
    endtask

    // load a table segment, encode symbols from it, flush
    task automatic run_phase();
        int n;
        int lo;
        int cum;
        int max_w;
        int k;
        int roll;
        n     = $urandom_range(2, 8);
        lo    = ($urandom_range(0, 3) == 0) ? ALPHABET_SIZE - n
                                            : $urandom_range(0, ALPHABET_SIZE - n);
        max_w = modulus / n;
        if (max_w < 1) max_w = 1;
        cum   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, VALUE_MAX / 2)
                                            : $urandom_range(0, 1000);
        for (int i = 0; i <= n; i++) begin
            offer(row(OP_LOAD, lo + i, cum, $urandom_range(0, ALPHABET_SIZE - 1)));
            roll = $urandom_range(0, 9);
            // mostly growing entries, some zero-width and some falling back
            if (roll == 0) cum = cum;
            else if (roll == 1 && cum > 0) cum = cum - $urandom_range(1, cum);
            else cum = cum + $urandom_range(1, max_w);
            if (cum > VALUE_MAX) cum = VALUE_MAX;
        end
        k = $urandom_range(6, 14);
        for (int i = 0; i < k; i++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                offer(row(OP_RSVD, $urandom_range(0, INDEX_MAX),
                          $urandom_range(0, VALUE_MAX), $urandom_range(0, ALPHABET_SIZE - 1)));
            else if (roll == 1)
                offer(row(OP_LOAD, $urandom_range(TABLE_DEPTH, INDEX_MAX),
                          $urandom_range(0, VALUE_MAX), $urandom_range(0, ALPHABET_SIZE - 1)));
            else if (roll == 2)
                offer(row(OP_FLUSH, $urandom_range(0, INDEX_MAX),
                          $urandom_range(0, VALUE_MAX), $urandom_range(0, ALPHABET_SIZE - 1)));
            else
                offer(row(OP_ENCODE, $urandom_range(0, INDEX_MAX),
                          $urandom_range(0, VALUE_MAX), lo + $urandom_range(0, n - 1)));
        end
        offer(row(OP_FLUSH, $urandom_range(0, INDEX_MAX), $urandom_range(0, VALUE_MAX),
                  $urandom_range(0, ALPHABET_SIZE - 1)));
    endtask

    // result receiver: random stalls, one long hold when asked
    initial begin : receiver
        int held;
        forever begin
            if (hold_long) begin
                res_if.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // compare each accepted result with the oldest one due
    always @(posedge i_clk) begin : check_results
        result_t got;
        result_t want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.value = res_if.out_value;
            got.kind  = res_if.kind;
            got.last  = res_if.last;
            if (coder_outputs_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: actual value=%0h kind=%0d last=%0d",
                         $realtime, got.value, got.kind, got.last);
            end else begin
                want = coder_outputs_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    $display("%0t: mismatch: expected value=%0h kind=%0d last=%0d, actual value=%0h kind=%0d last=%0d",
                             $realtime, want.value, want.kind, want.last,
                             got.value, got.kind, got.last);
                end
                case (got.kind)
                    KIND_WORD:  words_seen++;
                    KIND_FINAL: finals_seen++;
                    default:    errors_seen++;
                endcase
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        stim_t       directed_rows [$];
        logic [20:0] totals [6];
        logic [5:0]  sizes [6];
        int          waited;
        item_if.valid       = 1'b0;
        item_if.operation   = OP_LOAD;
        item_if.table_index = '0;
        item_if.table_value = '0;
        item_if.symbol      = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        i_rst_n             = 1'b0;
        totals = '{21'd1, 21'd1048576, 21'd4096, 21'd65536, 21'd1048576, 21'd1000};
        sizes  = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd8, 6'd12};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: state after reset, extremes of every field, errors
        directed_rows.push_back(row_typed(OP_FLUSH, 0, 0, 0, 1, 52'd0, KIND_FINAL));
        directed_rows.push_back(row_typed(OP_FLUSH, 0, 0, 0, 1, 52'd1048576, KIND_FINAL));
        directed_rows.push_back(row_typed(OP_RSVD, INDEX_MAX, VALUE_MAX, 1023, 0, 0, KIND_WORD));
        directed_rows.push_back(row(OP_LOAD, 0, 0, 0));
        directed_rows.push_back(row(OP_LOAD, 1, 1, 0));
        directed_rows.push_back(row(OP_LOAD, 2, 1, 0));
        directed_rows.push_back(row(OP_LOAD, 3, 21'h80000, 0));
        directed_rows.push_back(row(OP_LOAD, 4, 21'h100000, 0));
        directed_rows.push_back(row(OP_LOAD, 5, 21'h7FFFF, 0));
        directed_rows.push_back(row_typed(OP_ENCODE, 0, 0, 1, 1, 0, KIND_ERR));
        directed_rows.push_back(row_typed(OP_ENCODE, 0, 0, 4, 1, 0, KIND_ERR));
        directed_rows.push_back(row(OP_ENCODE, 0, 0, 0));
        directed_rows.push_back(row(OP_ENCODE, 0, 0, 3));
        directed_rows.push_back(row(OP_ENCODE, 0, 0, 2));
        directed_rows.push_back(row(OP_FLUSH, 0, 0, 0));
        directed_rows.push_back(row(OP_LOAD, ALPHABET_SIZE, VALUE_MAX, 0));
        directed_rows.push_back(row(OP_LOAD, ALPHABET_SIZE - 1, 0, 0));
        directed_rows.push_back(row(OP_LOAD, INDEX_MAX, 21'h155555, 0));
        directed_rows.push_back(row_typed(OP_FLUSH, 0, 0, 0, 1, 52'd1048576, KIND_FINAL));
        directed_rows.push_back(row(OP_LOAD, TABLE_DEPTH, 21'h0AAAAA, 0));
        directed_rows.push_back(row(OP_ENCODE, 0, 0, ALPHABET_SIZE - 1));
        directed_rows.push_back(row(OP_ENCODE, 0, 0, 0));
        directed_rows.push_back(row(OP_ENCODE, 0, 0, ALPHABET_SIZE - 1));
        directed_rows.push_back(row(OP_FLUSH, 0, 0, 0));
        foreach (directed_rows[i]) offer(directed_rows[i]);

        // random phases, each under its own register setting
        while (items_sent < ITEM_TARGET) begin
            settle();
            if (phases_run < 6) begin
                reg_write(REG_TOTAL_COUNT, totals[phases_run]);
                reg_write(REG_WORD_BITS, sizes[phases_run]);
            end else begin
                reg_write(REG_TOTAL_COUNT, $urandom_range(1, 1048576));
                reg_write(REG_WORD_BITS, $urandom_range(0, 40));
            end
            if (phases_run == HOLD_PHASE) hold_long = 1'b1;
            run_phase();
            phases_run++;
        end
        item_if.valid <= 1'b0;

        // drain, then give the block time to show anything extra
        waited = 0;
        while (coder_outputs_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (coder_outputs_due.size() != 0) begin
            fail_count += coder_outputs_due.size();
            $display("%0t: %0d results never arrived, next expected value=%0h kind=%0d",
                     $realtime, coder_outputs_due.size(), coder_outputs_due[0].value,
                     coder_outputs_due[0].kind);
        end

        $display("run: %0d items over %0d register settings, incl. a %0d-cycle output stall",
                 items_sent, phases_run, HOLD_CYCLES);
        $display("results checked: %0d words, %0d final states, %0d zero-width errors",
                 words_seen, finals_seen, errors_seen);
        if (fail_count == 0) begin
            $display("rans_block_encoder_top_test: PASS");
        end else begin
            $display("rans_block_encoder_top_test: FAIL");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin : watchdog
        #6_000_000;
        $display("rans_block_encoder_top_test: FAIL");
        $finish;
    end

endmodule
